@@ rtl/core/ansi_sgr_color_decoder_top_defines.svh @@
// Assertion macros shared by the ANSI SGR decoder RTL.
// Each macro expects clk and rst_n in scope at the point of use.
`ifndef ANSI_SGR_COLOR_DECODER_TOP_DEFINES_SVH
`define ANSI_SGR_COLOR_DECODER_TOP_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define ASGR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset
`define ASGR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/asgr_pkg.sv @@
`default_nettype none

package asgr_pkg;

  // Control bytes of an SGR sequence
  localparam logic [7:0] ESC_BYTE  = 8'h1B;
  localparam logic [7:0] OPEN_BYTE = 8'h5B;
  localparam logic [7:0] END_BYTE  = 8'h6D;
  localparam logic [7:0] SEP_BYTE  = 8'h3B;
  localparam logic [7:0] DIGIT_LO  = 8'h30;
  localparam logic [7:0] DIGIT_HI  = 8'h39;

  // SGR codes
  localparam logic [7:0] CODE_RESET  = 8'd0;
  localparam logic [7:0] CODE_BOLD   = 8'd1;
  localparam logic [7:0] CODE_BLINK  = 8'd5;
  localparam logic [7:0] CODE_FG_LO  = 8'd30;
  localparam logic [7:0] CODE_FG_HI  = 8'd37;
  localparam logic [7:0] ACC_MAX     = 8'hFF;

  // Default attribute register value after reset
  localparam logic [7:0] ATTR_RESET = 8'h07;

  typedef enum logic [1:0] {
    MODE_PLAIN = 2'd0,
    MODE_ESC   = 2'd1,
    MODE_SEQ   = 2'd2
  } mode_t;

  // One input word
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } item_t;

  // One result word
  typedef struct packed {
    logic       text_vld;
    logic [7:0] data;
    logic [7:0] attr;
  } result_t;

  // Foreground bits for codes 30..37, indexed by (code - 30) mod 8
  function automatic logic [2:0] fg_color(input logic [2:0] idx);
    logic [2:0] c;
    case (idx)
      3'd0:    c = 3'd0;
      3'd1:    c = 3'd4;
      3'd2:    c = 3'd2;
      3'd3:    c = 3'd6;
      3'd4:    c = 3'd1;
      3'd5:    c = 3'd5;
      3'd6:    c = 3'd3;
      default: c = 3'd7;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/asgr_in_reg.sv @@
`default_nettype none

module asgr_in_reg (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire logic [7:0]     in_byte,
  input  wire logic           in_ends_message,
  input  wire logic           advance,
  output logic                item_vld,
  output asgr_pkg::item_t     item
);
  import asgr_pkg::*;

  logic  vld_r, vld_nxt;
  item_t item_r;
  logic  load;

  // Hold the word only while the stage below is blocked
  assign in_stall = vld_r & ~advance;
  assign load     = in_valid & ~in_stall;

  always_comb begin
    vld_nxt = vld_r;
    if (load) begin
      vld_nxt = 1'b1;
    end else if (advance) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Payload, no reset needed
  always_ff @(posedge clk) begin
    if (load) begin
      item_r.data <= in_byte;
      item_r.last <= in_ends_message;
    end
  end

  assign item_vld = vld_r;
  assign item     = item_r;

endmodule

`default_nettype wire

@@ rtl/core/asgr_core.sv @@
`default_nettype none

`include "ansi_sgr_color_decoder_top_defines.svh"

module asgr_core (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            fire,
  input  wire asgr_pkg::item_t item,
  input  wire logic [7:0]      cfg_attr,
  output asgr_pkg::result_t    res
);
  import asgr_pkg::*;

  mode_t      mode_r, mode_nxt;
  logic [7:0] acc_r, acc_nxt;
  // intensity {bit7, bit3}, color {bg[2:0], fg[2:0]}
  logic [1:0] int_r, int_nxt;
  logic [5:0] col_r, col_nxt;

  logic [7:0]  b;
  logic        is_digit;
  logic [11:0] acc_x10;
  logic [11:0] acc_sum;
  logic [7:0]  acc_sat;
  logic        text_vld;

  assign b        = item.data;
  assign is_digit = (b >= DIGIT_LO) && (b <= DIGIT_HI);

  // acc * 10 + digit, saturating at 255
  assign acc_x10 = {1'b0, acc_r, 3'b000} + {3'b000, acc_r, 1'b0};
  assign acc_sum = acc_x10 + {8'h00, b[3:0]};
  assign acc_sat = (acc_sum > {4'h0, ACC_MAX}) ? ACC_MAX : acc_sum[7:0];

  // Parser next state and attribute update
  always_comb begin
    mode_nxt = mode_r;
    acc_nxt  = acc_r;
    int_nxt  = int_r;
    col_nxt  = col_r;
    text_vld = 1'b0;
    unique case (mode_r)
      MODE_ESC: begin
        if (b == ESC_BYTE) begin
          mode_nxt = MODE_ESC;
        end else if (b == OPEN_BYTE) begin
          mode_nxt = MODE_SEQ;
          acc_nxt  = 8'h00;
        end else begin
          text_vld = 1'b1;
          mode_nxt = MODE_PLAIN;
        end
      end
      MODE_SEQ: begin
        if (b == ESC_BYTE) begin
          mode_nxt = MODE_ESC;
          acc_nxt  = 8'h00;
        end else if (is_digit) begin
          acc_nxt = acc_sat;
        end else if ((b == END_BYTE) || (b == SEP_BYTE)) begin
          // apply the pending code
          if (acc_r == CODE_RESET) begin
            int_nxt = {cfg_attr[7], cfg_attr[3]};
            col_nxt = {cfg_attr[6:4], cfg_attr[2:0]};
          end else if ((acc_r == CODE_BOLD) || (acc_r == CODE_BLINK)) begin
            int_nxt = {cfg_attr[7], ~cfg_attr[3]};
          end else if (acc_r == CODE_FG_LO) begin
            col_nxt = 6'b111_000;
          end else if ((acc_r > CODE_FG_LO) && (acc_r <= CODE_FG_HI)) begin
            col_nxt = {cfg_attr[6:4], fg_color(acc_r[2:0] - CODE_FG_LO[2:0])};
          end
          acc_nxt = 8'h00;
          if (b == END_BYTE) begin
            mode_nxt = MODE_PLAIN;
          end
        end
      end
      default: begin
        // plain text, and the unused code behaves the same
        if (b == ESC_BYTE) begin
          mode_nxt = MODE_ESC;
          acc_nxt  = 8'h00;
        end else begin
          text_vld = 1'b1;
          mode_nxt = MODE_PLAIN;
        end
      end
    endcase
    if (item.last) begin
      mode_nxt = MODE_PLAIN;
      acc_nxt  = 8'h00;
    end
  end

  // Parser and attribute state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_PLAIN;
      acc_r  <= 8'h00;
      int_r  <= {ATTR_RESET[7], ATTR_RESET[3]};
      col_r  <= {ATTR_RESET[6:4], ATTR_RESET[2:0]};
    end else if (fire) begin
      mode_r <= mode_nxt;
      acc_r  <= acc_nxt;
      int_r  <= int_nxt;
      col_r  <= col_nxt;
    end
  end

  // Result word carries the attribute after this byte
  assign res.text_vld = text_vld;
  assign res.data     = text_vld ? b : 8'h00;
  assign res.attr     = {int_nxt[1], col_nxt[5:3], int_nxt[0], col_nxt[2:0]};

  `ASGR_ASSERT_NOW(a_acc_only_in_seq, mode_r != MODE_SEQ, acc_r == 8'h00,
    "code accumulator nonzero outside a sequence")
  `ASGR_ASSERT_NEXT(a_last_clears_parse, fire && item.last,
    (mode_r == MODE_PLAIN) && (acc_r == 8'h00), "parse state not cleared at message end")
  `ASGR_ASSERT_NEXT(a_attr_idle_hold, !fire, $stable(int_r) && $stable(col_r),
    "attribute changed without an accepted word")

endmodule

`default_nettype wire

@@ rtl/core/ansi_sgr_color_decoder_top.sv @@
// ANSI SGR color decoder.
// Input channel (in_valid / in_stall): one text byte per word, with
// in_ends_message set on the last byte of a message. Escape sequences
// ESC '[' codes 'm' are consumed; other bytes come back as text.
// Output channel (out_valid / out_stall): exactly one result word per
// input word, in order. out_out_valid tells whether out_byte is text;
// out_text_attribute is the console attribute after that byte.
// Config port (cfg_valid / cfg_ready): writes the default attribute word,
// always ready; write it only while no word is in flight.
// A word accepted into the input register passes through the parser into the
// result register, from which the output presents it; a stall can hold it in
// either register. Throughput: one word per cycle while out_stall is low, set by
// the combinational parser update between the two registers.
// Reset (rst_n low, synchronous): both registers empty, parser in plain
// text, default attribute 0x07, current attribute 0x07.
// A stalled result holds; the input register keeps taking words until it
// too is full, then in_stall rises in the same cycle as the back-pressure.
`default_nettype none

`include "ansi_sgr_color_decoder_top_defines.svh"

module ansi_sgr_color_decoder_top (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_ends_message,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            out_out_valid,
  output logic [7:0]      out_byte,
  output logic [7:0]      out_text_attribute,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [7:0] cfg_data
);
  import asgr_pkg::*;

  logic       cfg_attr_r;
  logic [7:0] attr_reg_r;
  logic       item_vld;
  item_t      item;
  logic       advance;
  logic       fire;
  result_t    res;
  logic       out_vld_r, out_vld_nxt;
  result_t    res_r;

  // Config register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_reg_r <= ATTR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      attr_reg_r <= cfg_data;
    end
  end

  // Flag a config write for the idle check below
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_attr_r <= 1'b0;
    end else begin
      cfg_attr_r <= cfg_valid & cfg_ready;
    end
  end

  // Result register may load when empty or being drained
  assign advance = ~out_vld_r | ~out_stall;
  assign fire    = item_vld & advance;

  asgr_in_reg u_in_reg (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_byte         (in_byte),
    .in_ends_message (in_ends_message),
    .advance         (advance),
    .item_vld        (item_vld),
    .item            (item)
  );

  asgr_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .fire     (fire),
    .item     (item),
    .cfg_attr (attr_reg_r),
    .res      (res)
  );

  // Result register
  always_comb begin
    out_vld_nxt = out_vld_r;
    if (fire) begin
      out_vld_nxt = 1'b1;
    end else if (!out_stall) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res;
    end
  end

  assign out_valid          = out_vld_r;
  assign out_out_valid      = res_r.text_vld;
  assign out_byte           = res_r.data;
  assign out_text_attribute = res_r.attr;

  `ASGR_ASSERT_NOW(a_consumed_byte_zero, out_vld_r && !res_r.text_vld,
    res_r.data == 8'h00, "consumed word carries a nonzero byte")
  `ASGR_ASSERT_NOW(a_stall_only_when_full, in_stall,
    item_vld && out_vld_r && out_stall, "input stalled with room downstream")
  `ASGR_ASSERT_NOW(a_cfg_when_idle, cfg_attr_r, !(out_vld_r && item_vld && !advance),
    "config write landed behind a blocked pipeline")

endmodule

`default_nettype wire
